### rtl/core/dq_pkg.sv
// Package for the double-ended queue: request and status codes, the sequencer
// states and the packed request and result layouts used on the stream ports.
// No dependencies.
package dq_pkg;

    localparam int REQ_W    = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int IN_BITS  = 40;
    localparam int OUT_BITS = 40;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ       = 3'd4,
        REQ_INSERT     = 3'd5,
        REQ_ERASE      = 3'd6,
        REQ_CLEAR      = 3'd7
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        DQ_IDLE,
        DQ_RDATA,
        DQ_SHIFT_RD,
        DQ_SHIFT_WR,
        DQ_DONE
    } state_t;

    // The last field sits in the lowest bits.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
        logic [REQ_W-1:0]   req_type;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
        logic [VALUE_W-1:0] read_value;
    } result_t;

endpackage

### rtl/core/dq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/double_ended_queue.sv
// Bounded double-ended queue of CAPACITY words held as a ring in one RAM. Each
// request on s_tdata pushes or pops at either end, reads, inserts before or
// erases at a position, or clears; each returns one result on m_tdata with the
// word read or removed, the new count, an empty flag and a status, and a failed
// request leaves the queue as it was. Push, clear and any failed request go
// straight to the result step; pop, read and erase first take the word read
// in a read-data step; insert and erase then move each entry between the
// position and the back with one RAM read and one RAM write per entry, as
// the RAM has a single read port with a registered read. A new request is
// taken while the previous result still waits on m_.
// Depends on dq_pkg and dq_ram.
module double_ended_queue #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // req_type[2:0], position[7:3], value[39:8]
    input  logic [dq_pkg::IN_BITS-1:0]   s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // read_value[31:0], entry_count[36:32], is_empty[37], status[39:38]
    output logic [dq_pkg::OUT_BITS-1:0]  m_tdata
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int SW  = CW + 1;
    localparam int PW  = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;
    localparam int XW  = (WORD_BITS > dq_pkg::VALUE_W) ? WORD_BITS : dq_pkg::VALUE_W;
    localparam int XCW = (CW > dq_pkg::COUNT_W) ? CW : dq_pkg::COUNT_W;

    localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
    localparam logic [CW-1:0] LAST_C   = CW'(CAPACITY - 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(CAPACITY - 1);

    dq_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    front_reg, front_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [WORD_BITS-1:0] val_reg, val_next;
    logic [WORD_BITS-1:0] rd_reg, rd_next;
    dq_pkg::req_t     op_reg, op_next;
    dq_pkg::status_t  status_reg, status_next;
    logic             m_valid_reg, m_valid_next;
    dq_pkg::result_t  result_reg, result_next;

    dq_pkg::request_t req;
    dq_pkg::req_t     in_req;
    dq_pkg::status_t  in_err;
    logic             s_fire;
    logic             out_free;
    logic [PW-1:0]    in_pos_x;
    logic [PW-1:0]    cnt_x;
    logic [CW-1:0]    in_pos_c;
    logic [XW-1:0]    val_x;
    logic [WORD_BITS-1:0] in_val;
    logic [XW-1:0]    rd_x;
    logic [XCW-1:0]   cnt_xc;

    logic [CW-1:0]    lidx;
    logic [SW-1:0]    rsum;
    logic [SW-1:0]    rsum_w;
    logic [IW-1:0]    ring_addr;
    logic [IW-1:0]    front_inc;
    logic             shift_end;
    logic [CW-1:0]    shift_src;

    logic                 ram_we;
    logic                 ram_re;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    assign req      = dq_pkg::request_t'(s_tdata);
    assign in_req   = dq_pkg::req_t'(req.req_type);
    assign in_pos_x = PW'(req.position);
    assign cnt_x    = PW'(count_reg);
    assign in_pos_c = CW'(req.position);
    assign val_x    = XW'(req.value);
    assign in_val   = val_x[WORD_BITS-1:0];
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Error check on the incoming request, against the state before it.
    always_comb begin
        in_err = dq_pkg::ST_OK;
        unique case (in_req) inside
            dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
                if (count_reg == CAP_C) in_err = dq_pkg::ST_FULL;
            end
            dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
                if (count_reg == '0) in_err = dq_pkg::ST_EMPTY;
            end
            dq_pkg::REQ_READ, dq_pkg::REQ_ERASE: begin
                if (in_pos_x >= cnt_x) in_err = dq_pkg::ST_RANGE;
            end
            dq_pkg::REQ_INSERT: begin
                if (count_reg == CAP_C) begin
                    in_err = dq_pkg::ST_FULL;
                end else if (in_pos_x > cnt_x) begin
                    in_err = dq_pkg::ST_RANGE;
                end
            end
            dq_pkg::REQ_CLEAR: begin
                in_err = dq_pkg::ST_OK;
            end
        endcase
    end

    // Logical index to ring slot: the sum stays below twice the capacity.
    always_comb begin
        rsum = SW'(front_reg) + SW'(lidx);
        if (rsum >= SW'(CAPACITY)) begin
            rsum_w = rsum - SW'(CAPACITY);
        end else begin
            rsum_w = rsum;
        end
        ring_addr = rsum_w[IW-1:0];
    end

    assign front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;

    // Insert walks down from the back, erase walks up from the hole.
    assign shift_end = (op_reg == dq_pkg::REQ_INSERT) ? (idx_reg == pos_reg)
                     : (({1'b0, idx_reg} + 1'b1) == {1'b0, count_reg});
    assign shift_src = (op_reg == dq_pkg::REQ_INSERT) ? idx_reg - 1'b1 : idx_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dq_pkg::DQ_IDLE: begin
                if (s_fire) begin
                    if (in_err != dq_pkg::ST_OK) begin
                        state_next = dq_pkg::DQ_DONE;
                    end else begin
                        unique case (in_req) inside
                            dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK,
                            dq_pkg::REQ_CLEAR: state_next = dq_pkg::DQ_DONE;
                            dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK,
                            dq_pkg::REQ_READ, dq_pkg::REQ_ERASE:
                                state_next = dq_pkg::DQ_RDATA;
                            dq_pkg::REQ_INSERT: state_next = dq_pkg::DQ_SHIFT_RD;
                        endcase
                    end
                end
            end
            dq_pkg::DQ_RDATA: begin
                state_next = (op_reg == dq_pkg::REQ_ERASE) ? dq_pkg::DQ_SHIFT_RD
                                                            : dq_pkg::DQ_DONE;
            end
            dq_pkg::DQ_SHIFT_RD: begin
                state_next = shift_end ? dq_pkg::DQ_DONE : dq_pkg::DQ_SHIFT_WR;
            end
            dq_pkg::DQ_SHIFT_WR: begin
                state_next = dq_pkg::DQ_SHIFT_RD;
            end
            dq_pkg::DQ_DONE: begin
                if (out_free) state_next = dq_pkg::DQ_IDLE;
            end
            default: begin
                state_next = dq_pkg::DQ_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == dq_pkg::DQ_IDLE);
        count_next  = count_reg;
        front_next  = front_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        rd_next     = rd_reg;
        op_next     = op_reg;
        status_next = status_reg;
        result_next = result_reg;
        m_valid_next = m_valid_reg && !m_tready;
        lidx        = idx_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = val_reg;
        rd_x        = XW'(rd_reg);
        cnt_xc      = XCW'(count_reg);

        unique case (state_reg)
            dq_pkg::DQ_IDLE: begin
                if (s_fire) begin
                    op_next     = in_req;
                    pos_next    = in_pos_c;
                    val_next    = in_val;
                    rd_next     = '0;
                    status_next = in_err;
                    if (in_err == dq_pkg::ST_OK) begin
                        unique case (in_req)
                            dq_pkg::REQ_PUSH_FRONT: begin
                                // Slot CAPACITY-1 past the front is the one before it.
                                lidx       = LAST_C;
                                ram_we     = 1'b1;
                                ram_wdata  = in_val;
                                front_next = ring_addr;
                                count_next = count_reg + 1'b1;
                            end
                            dq_pkg::REQ_PUSH_BACK: begin
                                lidx       = count_reg;
                                ram_we     = 1'b1;
                                ram_wdata  = in_val;
                                count_next = count_reg + 1'b1;
                            end
                            dq_pkg::REQ_POP_FRONT: begin
                                lidx       = '0;
                                ram_re     = 1'b1;
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                            end
                            dq_pkg::REQ_POP_BACK: begin
                                lidx       = count_reg - 1'b1;
                                ram_re     = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                            dq_pkg::REQ_READ: begin
                                lidx   = in_pos_c;
                                ram_re = 1'b1;
                            end
                            dq_pkg::REQ_ERASE: begin
                                lidx     = in_pos_c;
                                ram_re   = 1'b1;
                                idx_next = in_pos_c;
                            end
                            dq_pkg::REQ_INSERT: begin
                                idx_next = count_reg;
                            end
                            dq_pkg::REQ_CLEAR: begin
                                count_next = '0;
                                front_next = '0;
                            end
                        endcase
                    end
                end
            end
            dq_pkg::DQ_RDATA: begin
                rd_next = ram_rdata;
            end
            dq_pkg::DQ_SHIFT_RD: begin
                if (shift_end) begin
                    if (op_reg == dq_pkg::REQ_INSERT) begin
                        lidx       = idx_reg;
                        ram_we     = 1'b1;
                        ram_wdata  = val_reg;
                        count_next = count_reg + 1'b1;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end else begin
                    lidx   = shift_src;
                    ram_re = 1'b1;
                end
            end
            dq_pkg::DQ_SHIFT_WR: begin
                lidx      = idx_reg;
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                idx_next  = shift_src;
            end
            dq_pkg::DQ_DONE: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    result_next.read_value  = rd_x[dq_pkg::VALUE_W-1:0];
                    result_next.entry_count = cnt_xc[dq_pkg::COUNT_W-1:0];
                    result_next.is_empty    = (count_reg == '0);
                    result_next.status      = status_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dq_pkg::DQ_IDLE;
            count_reg   <= '0;
            front_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            front_reg   <= front_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        rd_reg     <= rd_next;
        op_reg     <= op_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    dq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ring_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ring_addr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("entry count exceeds capacity");

    a_front_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, front_reg} < (IW + 1)'(CAPACITY))
        else $error("front slot outside the ring");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (in_req == dq_pkg::REQ_PUSH_FRONT || in_req == dq_pkg::REQ_PUSH_BACK)
        && count_reg != CAP_C |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("successful push did not grow the count by one");

    a_err_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && in_err != dq_pkg::ST_OK |=>
        count_reg == $past(count_reg) && front_reg == $past(front_reg))
        else $error("failed request changed the queue");

    a_no_write_late: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dq_pkg::DQ_DONE || state_reg == dq_pkg::DQ_RDATA) |-> !ram_we)
        else $error("RAM written outside an update step");
`endif

endmodule
